FILE: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tfws_pkg.sv
// Shared types and codes for the two-flow weighted scheduler.
// No dependencies; used by tfws_cell, tfws_queue and the top level.
package tfws_pkg;

    // Field widths
    localparam int ID_W     = 8;
    localparam int SLOT_W   = 16;
    localparam int WEIGHT_W = 4;
    localparam int STATUS_W = 2;

    // Command codes
    localparam logic CMD_ENQUEUE = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    // Flow codes
    localparam logic FLOW_ONE = 1'b0;
    localparam logic FLOW_TWO = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SENT     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DROPPED  = 2'd3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 4'd2;

    // One queued packet: arrival stamp over id
    typedef struct packed {
        logic [SLOT_W-1:0] stamp;
        logic [ID_W-1:0]   id;
    } t_entry;

    // Queue occupancy flags reported to the arbiter
    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

FILE: rtl/two_flow_weighted_scheduler.sv
// Two-flow weighted round-robin scheduler: top level, arbiter and result register.
// Depends on tfws_pkg and tfws_queue; includes assert_macros.svh.
// A result is registered at its item's transfer and appears in the cycle after it.
// Throughput: one item per cycle while the result stream is taken; each queue is
//   a chain of cells that pushes or shifts in place, without stalling.
// Reset (synchronous, active low): queues empty, turn and slot counters zero, weight 2.
`include "assert_macros.svh"

module two_flow_weighted_scheduler #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: flow one weight
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] packet_id
    input  logic [1:0]  i_s_axis_tuser,   // [0] command, [1] flow_select
    // Result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] sent_id, [8] sent_flow,
                                          // [24:9] end_slot, [40:25] delay, rest zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    localparam int SW = tfws_pkg::SLOT_W;

    logic [tfws_pkg::WEIGHT_W-1:0] r_weight;
    logic [tfws_pkg::WEIGHT_W-1:0] r_turn;
    logic [tfws_pkg::WEIGHT_W-1:0] n_turn;
    logic [SW-1:0]                 r_slot;
    logic                          r_m_valid;
    logic [tfws_pkg::STATUS_W-1:0] r_status;
    logic [tfws_pkg::STATUS_W-1:0] n_status;
    logic [tfws_pkg::ID_W-1:0]     r_sent_id;
    logic [tfws_pkg::ID_W-1:0]     n_sent_id;
    logic                          r_sent_flow;
    logic                          n_sent_flow;
    logic [SW-1:0]                 r_end;
    logic [SW-1:0]                 n_end;
    logic [SW-1:0]                 r_delay;
    logic [SW-1:0]                 n_delay;

    logic             w_accept;
    logic             w_tick;
    logic             w_enq;
    logic             w_cmd;
    logic             w_flow;
    logic             w_favor_one;
    logic             w_pick_one;
    logic             w_pick_two;
    logic [SW-1:0]    w_slot_inc;
    tfws_pkg::t_entry w_push_data;
    tfws_pkg::t_entry w_head_one;
    tfws_pkg::t_entry w_head_two;
    tfws_pkg::t_entry w_head_sel;
    tfws_pkg::t_queue_status w_st_one;
    tfws_pkg::t_queue_status w_st_two;

    // Input decode
    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd           = i_s_axis_tuser[0];
    assign w_flow          = i_s_axis_tuser[1];
    assign w_tick          = w_accept && (w_cmd == tfws_pkg::CMD_TICK);
    assign w_enq           = w_accept && (w_cmd == tfws_pkg::CMD_ENQUEUE);
    assign w_slot_inc      = r_slot + SW'(1);

    assign w_push_data.stamp = r_slot;
    assign w_push_data.id    = i_s_axis_tdata;

    // Per-flow queues
    tfws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_one (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_enq && (w_flow == tfws_pkg::FLOW_ONE)),
        .i_pop       (w_tick && w_pick_one),
        .i_push_data (w_push_data),
        .o_head      (w_head_one),
        .o_status    (w_st_one)
    );

    tfws_queue #(.DEPTH(QUEUE_DEPTH)) u_queue_two (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_enq && (w_flow == tfws_pkg::FLOW_TWO)),
        .i_pop       (w_tick && w_pick_two),
        .i_push_data (w_push_data),
        .o_head      (w_head_two),
        .o_status    (w_st_two)
    );

    // Weighted arbitration, work conserving
    assign w_favor_one = (r_turn < r_weight);
    assign w_pick_one  = w_favor_one ? !w_st_one.empty
                                     : (w_st_two.empty && !w_st_one.empty);
    assign w_pick_two  = w_favor_one ? (w_st_one.empty && !w_st_two.empty)
                                     : !w_st_two.empty;
    assign w_head_sel  = w_pick_two ? w_head_two : w_head_one;

    always_comb begin
        n_turn = r_turn;
        if (w_tick && w_pick_one) begin
            n_turn = w_favor_one ? (r_turn + 4'd1) : 4'd1;
        end else if (w_tick && w_pick_two) begin
            n_turn = '0;
        end
    end

    // Result fields
    always_comb begin
        n_status    = tfws_pkg::STATUS_IDLE;
        n_sent_id   = '0;
        n_sent_flow = tfws_pkg::FLOW_ONE;
        n_end       = '0;
        n_delay     = '0;
        if (w_cmd == tfws_pkg::CMD_ENQUEUE) begin
            if (w_flow == tfws_pkg::FLOW_TWO) begin
                n_status = w_st_two.full ? tfws_pkg::STATUS_DROPPED
                                         : tfws_pkg::STATUS_ENQUEUED;
            end else begin
                n_status = w_st_one.full ? tfws_pkg::STATUS_DROPPED
                                         : tfws_pkg::STATUS_ENQUEUED;
            end
        end else begin
            n_end = w_slot_inc;
            if (w_pick_one || w_pick_two) begin
                n_status    = tfws_pkg::STATUS_SENT;
                n_sent_id   = w_head_sel.id;
                n_sent_flow = w_pick_two ? tfws_pkg::FLOW_TWO : tfws_pkg::FLOW_ONE;
                n_delay     = w_slot_inc - w_head_sel.stamp;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight  <= tfws_pkg::WEIGHT_RESET;
            r_turn    <= '0;
            r_slot    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_weight <= i_cfg_wdata;
            end
            r_turn <= n_turn;
            if (w_tick) begin
                r_slot <= w_slot_inc;
            end
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_status    <= n_status;
            r_sent_id   <= n_sent_id;
            r_sent_flow <= n_sent_flow;
            r_end       <= n_end;
            r_delay     <= n_delay;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tuser  = r_status;
    assign o_m_axis_tdata  = {7'd0, r_delay, r_end, r_sent_flow, r_sent_id};

    `ASSERT_IMPLIES(a_one_pick, i_clk, i_rst_n, w_tick, !(w_pick_one && w_pick_two), "both flows picked")
    `ASSERT_NEXT(a_tick_end, i_clk, i_rst_n, w_tick, r_m_valid && (r_end == $past(r_slot) + SW'(1)), "tick end slot mismatch")
    `ASSERT_NEXT(a_enq_hold, i_clk, i_rst_n, w_enq, (r_slot == $past(r_slot)) && (r_turn == $past(r_turn)), "enqueue changed schedule state")

endmodule

FILE: rtl/tfws_cell.sv
// One storage cell of the queue chain: loads a new entry or takes its neighbor's.
// Depends on tfws_pkg for the entry type.
module tfws_cell (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_shift,
    input  tfws_pkg::t_entry i_load_data,
    input  tfws_pkg::t_entry i_next_data,
    output tfws_pkg::t_entry o_data
);

    tfws_pkg::t_entry r_data;

    // Push writes this cell; pop moves the chain one step toward the head
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

FILE: rtl/tfws_queue.sv
// Packet FIFO built as a chain of tfws_cell; cell 0 holds the oldest entry when not empty.
// Depends on tfws_pkg and tfws_cell; includes assert_macros.svh.
`include "assert_macros.svh"

module tfws_queue #(
    parameter int DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic                  i_pop,
    input  tfws_pkg::t_entry      i_push_data,
    output tfws_pkg::t_entry      o_head,
    output tfws_pkg::t_queue_status o_status
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    tfws_pkg::t_entry w_data [DEPTH];
    logic             w_do_push;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CW'(DEPTH));
    assign w_do_push      = i_push && !o_status.full;

    // Cell chain: the free cell at the fill level loads, pop shifts all
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        tfws_pkg::t_entry w_next;
        if (k == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_data[k+1];
        end

        tfws_cell u_cell (
            .i_clk       (i_clk),
            .i_load      (w_do_push && (r_count == CW'(k))),
            .i_shift     (i_pop),
            .i_load_data (i_push_data),
            .i_next_data (w_next),
            .o_data      (w_data[k])
        );
    end

    assign o_head = w_data[0];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (w_do_push) begin
            n_count = r_count + CW'(1);
        end else if (i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CW'(DEPTH), "queue count above depth")
    `ASSERT_IMPLIES(a_pop_nonempty, i_clk, i_rst_n, i_pop, !o_status.empty && !i_push, "bad pop")
    `ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, i_push && o_status.full, r_count == $past(r_count), "push into full queue changed count")

endmodule
